// ===== src/udpd_pkg.sv =====
// shared constants and types for the udp port demux queue
package udpd_pkg;

  localparam int SOCKETS_DEF    = 32;
  localparam int RING_DEPTH_DEF = 16;

  // item modes
  localparam logic [1:0] MODE_BIND    = 2'd0;
  localparam logic [1:0] MODE_DELIVER = 2'd1;
  localparam logic [1:0] MODE_RECEIVE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_SOCKET  = 3'd1;
  localparam logic [2:0] ST_QUEUE_FULL = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;
  localparam logic [2:0] ST_NOT_UDP    = 3'd5;
  localparam logic [2:0] ST_ARP        = 3'd6;
  localparam logic [2:0] ST_OTHER      = 3'd7;

  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [15:0] ETYPE_ARP     = 16'h0806;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [12:0] MIN_ARP_LEN   = 13'd42;  // eth + arp
  localparam logic [12:0] MIN_IP_LEN    = 13'd34;  // eth + ip
  localparam logic [12:0] MIN_UDP_LEN   = 13'd42;  // eth + ip + udp
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_ENTRY,
    S_OUT
  } fsm_t;

  // request to the socket table scanner
  typedef struct packed {
    logic        start;
    logic        free_scan;   // look for a free slot instead of a port match
    logic [15:0] port;
  } tbl_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } tbl_stat_t;

  typedef struct packed {
    logic       udp_ok;
    logic [2:0] status;
  } frame_class_t;

endpackage

// ===== src/udp_port_demux_queue_unit.sv =====
// udp port demux queue: socket table, descriptor rings and item sequencer
//
// Input channel in_valid/in_ready carries one word per operation: bind a port
// (mode 0), deliver a received frame (mode 1) or receive from a port (mode 2).
// Each word gives exactly one result word on out_valid/out_ready with status,
// slot and, for a successful receive, the dequeued descriptor and copy length.
// Items are handled one at a time. A port lookup or free-slot search scans
// the socket memory one slot per cycle; the path an item takes depends on its mode:
//   frames rejected by classification or unused mode: no scan, straight to the result
//   bind and deliver: the scan, ending at the slot found or after the last slot on a miss
//   receive with data: the scan, then a read of the descriptor memory
// in_ready rises again the cycle after the result is loaded.
// The result sits in an output register; the next item is taken and worked on
// while it waits, and only its own result waits for out_ready.
// Reset clears all bound bits, so every slot is free; ring state and
// descriptors are written before they are read and need no clearing pass.
module udp_port_demux_queue_unit import udpd_pkg::*; #(
  parameter int SOCKETS    = SOCKETS_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_port,
  input  logic [15:0] in_ethertype,
  input  logic [12:0] in_frame_len,
  input  logic [7:0]  in_ip_protocol,
  input  logic [31:0] in_src_ip,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_udp_length,
  input  logic [15:0] in_buf_handle,
  input  logic [15:0] in_max_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [4:0]  out_slot,
  output logic [31:0] out_src_ip,
  output logic [15:0] out_src_port,
  output logic [15:0] out_copy_len,
  output logic [15:0] out_handle
);

  localparam int SW      = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;
  localparam int RW      = $clog2(RING_DEPTH);
  localparam int CW      = $clog2(RING_DEPTH + 1);
  localparam int ENTRIES = SOCKETS * RING_DEPTH;
  localparam int EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [EW-1:0] RD_W     = EW'(RING_DEPTH);
  localparam logic [RW-1:0] PTR_LAST = RW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(RING_DEPTH);

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] ulen;
    logic [15:0] handle;
  } desc_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] len;
    logic [15:0] handle;
  } res_t;

  fsm_t state_r, state_nxt;
  res_t res_r, res_nxt;
  res_t out_r;
  logic out_valid_r;
  logic out_load;

  logic [1:0]  mode_r;
  logic [15:0] port_r;
  logic [15:0] etype_r;
  logic [12:0] flen_r;
  logic [7:0]  proto_r;
  logic [31:0] sip_r;
  logic [15:0] sport_r;
  logic [15:0] ulen_r;
  logic [15:0] handle_r;
  logic [15:0] maxlen_r;

  desc_t emem [ENTRIES];
  desc_t erd_r;
  desc_t ewr_data;
  logic  ewr_en;
  logic  erd_en;
  logic [EW-1:0] e_addr;
  logic [EW-1:0] e_base;

  frame_class_t cls;

  tbl_req_t      tbl_req;
  tbl_stat_t     tbl_stat;
  logic [SW-1:0] hit_slot;
  logic [RW-1:0] rd_head;
  logic [RW-1:0] rd_tail;
  logic [CW-1:0] rd_count;
  logic          twr_en;
  logic          twr_set_bound;
  logic [RW-1:0] twr_head;
  logic [RW-1:0] twr_tail;
  logic [CW-1:0] twr_count;

  logic [15:0] pay_len;

  udpd_classify u_classify (
    .ethertype   (etype_r),
    .frame_len   (flen_r),
    .ip_protocol (proto_r),
    .cls         (cls)
  );

  udpd_sock_table #(
    .SOCKETS    (SOCKETS),
    .RING_DEPTH (RING_DEPTH)
  ) u_sock_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (tbl_req),
    .stat         (tbl_stat),
    .hit_slot     (hit_slot),
    .rd_head      (rd_head),
    .rd_tail      (rd_tail),
    .rd_count     (rd_count),
    .wr_en        (twr_en),
    .wr_set_bound (twr_set_bound),
    .wr_slot      (hit_slot),
    .wr_port      (port_r),
    .wr_head      (twr_head),
    .wr_tail      (twr_tail),
    .wr_count     (twr_count)
  );

  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign e_base   = EW'(hit_slot) * RD_W;

  assign ewr_data.ip     = sip_r;
  assign ewr_data.port   = sport_r;
  assign ewr_data.ulen   = ulen_r;
  assign ewr_data.handle = handle_r;

  // payload length: udp length less header, floored at zero
  assign pay_len = (erd_r.ulen >= UDP_HDR_BYTES) ? (erd_r.ulen - UDP_HDR_BYTES) : 16'd0;

  always_comb begin
    state_nxt         = state_r;
    res_nxt           = res_r;
    tbl_req.start     = 1'b0;
    tbl_req.free_scan = (mode_r == MODE_BIND);
    tbl_req.port      = port_r;
    twr_en            = 1'b0;
    twr_set_bound     = 1'b0;
    twr_head          = rd_head;
    twr_tail          = rd_tail;
    twr_count         = rd_count;
    ewr_en            = 1'b0;
    erd_en            = 1'b0;
    e_addr            = e_base + EW'(rd_tail);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_nxt        = '0;
        res_nxt.status = ST_OTHER;
        case (mode_r) inside
          MODE_BIND, MODE_RECEIVE: begin
            tbl_req.start = 1'b1;
            state_nxt     = S_SCAN;
          end
          MODE_DELIVER: begin
            if (cls.udp_ok) begin
              tbl_req.start = 1'b1;
              state_nxt     = S_SCAN;
            end else begin
              res_nxt.status = cls.status;
              state_nxt      = S_OUT;
            end
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_SCAN: begin
        if (tbl_stat.done) begin
          state_nxt = S_OUT;
          if (tbl_stat.hit) begin
            res_nxt.slot = 5'(hit_slot);
          end
          case (mode_r)
            MODE_BIND: begin
              if (tbl_stat.hit) begin
                twr_en         = 1'b1;
                twr_set_bound  = 1'b1;
                twr_head       = '0;
                twr_tail       = '0;
                twr_count      = '0;
                res_nxt.status = ST_OK;
              end else begin
                res_nxt.status = ST_TABLE_FULL;
              end
            end
            MODE_DELIVER: begin
              if (!tbl_stat.hit) begin
                res_nxt.status = ST_NO_SOCKET;
              end else if (rd_count == CNT_FULL) begin
                res_nxt.status = ST_QUEUE_FULL;
              end else begin
                ewr_en         = 1'b1;
                twr_en         = 1'b1;
                twr_tail       = (rd_tail == PTR_LAST) ? '0 : rd_tail + RW'(1);
                twr_count      = rd_count + CW'(1);
                res_nxt.status = ST_OK;
              end
            end
            default: begin
              e_addr = e_base + EW'(rd_head);
              if (!tbl_stat.hit) begin
                res_nxt.status = ST_NO_SOCKET;
              end else if (rd_count == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                erd_en         = 1'b1;
                twr_en         = 1'b1;
                twr_head       = (rd_head == PTR_LAST) ? '0 : rd_head + RW'(1);
                twr_count      = rd_count - CW'(1);
                res_nxt.status = ST_OK;
                state_nxt      = S_ENTRY;
              end
            end
          endcase
        end
      end
      S_ENTRY: begin
        res_nxt.ip     = erd_r.ip;
        res_nxt.port   = erd_r.port;
        res_nxt.handle = erd_r.handle;
        res_nxt.len    = (pay_len > maxlen_r) ? maxlen_r : pay_len;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
    if (in_valid && in_ready) begin
      mode_r   <= in_mode;
      port_r   <= in_port;
      etype_r  <= in_ethertype;
      flen_r   <= in_frame_len;
      proto_r  <= in_ip_protocol;
      sip_r    <= in_src_ip;
      sport_r  <= in_src_port;
      ulen_r   <= in_udp_length;
      handle_r <= in_buf_handle;
      maxlen_r <= in_max_len;
    end
  end

  // descriptor ring memory, one row of RING_DEPTH entries per slot
  always_ff @(posedge clk) begin
    if (ewr_en) begin
      emem[e_addr] <= ewr_data;
    end
    if (erd_en) begin
      erd_r <= emem[e_addr];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_r.status;
  assign out_slot     = out_r.slot;
  assign out_src_ip   = out_r.ip;
  assign out_src_port = out_r.port;
  assign out_copy_len = out_r.len;
  assign out_handle   = out_r.handle;

endmodule

// ===== src/udpd_classify.sv =====
// frame classifier: ethertype, length and ip protocol checks for deliver words
module udpd_classify import udpd_pkg::*; (
  input  logic [15:0]  ethertype,
  input  logic [12:0]  frame_len,
  input  logic [7:0]   ip_protocol,
  output frame_class_t cls
);

  always_comb begin
    cls.udp_ok = 1'b0;
    cls.status = ST_OTHER;
    if (ethertype == ETYPE_ARP && frame_len >= MIN_ARP_LEN) begin
      cls.status = ST_ARP;
    end else if (ethertype == ETYPE_IPV4 && frame_len >= MIN_IP_LEN) begin
      if (ip_protocol != PROTO_UDP || frame_len < MIN_UDP_LEN) begin
        cls.status = ST_NOT_UDP;
      end else begin
        cls.udp_ok = 1'b1;
        cls.status = ST_OK;
      end
    end
  end

endmodule

// ===== src/udpd_sock_table.sv =====
// socket table: bound bits, port and ring state memory, one-slot-per-cycle scanner
module udpd_sock_table import udpd_pkg::*; #(
  parameter int SOCKETS    = SOCKETS_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  localparam int SW   = (SOCKETS > 1) ? $clog2(SOCKETS) : 1,
  localparam int RW   = $clog2(RING_DEPTH),
  localparam int CW   = $clog2(RING_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tbl_req_t      req,
  output tbl_stat_t     stat,
  output logic [SW-1:0] hit_slot,
  output logic [RW-1:0] rd_head,
  output logic [RW-1:0] rd_tail,
  output logic [CW-1:0] rd_count,
  input  logic          wr_en,
  input  logic          wr_set_bound,
  input  logic [SW-1:0] wr_slot,
  input  logic [15:0]   wr_port,
  input  logic [RW-1:0] wr_head,
  input  logic [RW-1:0] wr_tail,
  input  logic [CW-1:0] wr_count
);

  localparam int CNTW = $clog2(SOCKETS + 1);
  localparam logic [SW-1:0]   LAST_IDX = SW'(SOCKETS - 1);
  localparam logic [CNTW-1:0] CNT_END  = CNTW'(SOCKETS);

  typedef struct packed {
    logic [15:0]   port;
    logic [RW-1:0] head;
    logic [RW-1:0] tail;
    logic [CW-1:0] count;
  } sock_t;

  sock_t           smem [SOCKETS];
  sock_t           rd_data_r;
  sock_t           wr_data;
  logic [SOCKETS-1:0] bound_r;

  logic            busy_r;
  logic            bind_r;
  logic [15:0]     port_r;
  logic [CNTW-1:0] cnt_r;
  logic            rd_vld_r;
  logic [SW-1:0]   rd_idx_r;

  logic            rd_en;
  logic            bound_bit;
  logic            match;
  logic            last;

  assign rd_en     = busy_r && (cnt_r < CNT_END);
  assign bound_bit = bound_r[rd_idx_r];
  assign match     = bind_r ? !bound_bit : (bound_bit && rd_data_r.port == port_r);
  assign last      = rd_vld_r && (rd_idx_r == LAST_IDX);

  assign stat.hit  = rd_vld_r && match;
  assign stat.done = busy_r && (stat.hit || last);
  assign hit_slot  = rd_idx_r;
  assign rd_head   = rd_data_r.head;
  assign rd_tail   = rd_data_r.tail;
  assign rd_count  = rd_data_r.count;

  assign wr_data.port  = wr_port;
  assign wr_data.head  = wr_head;
  assign wr_data.tail  = wr_tail;
  assign wr_data.count = wr_count;

  // writes only land after a scan has finished, so a read never meets a pending write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      smem[wr_slot] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= smem[cnt_r[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r  <= '0;
      busy_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en && wr_set_bound) begin
        bound_r[wr_slot] <= 1'b1;
      end
      if (req.start) begin
        busy_r   <= 1'b1;
        rd_vld_r <= 1'b0;
      end else if (stat.done) begin
        busy_r   <= 1'b0;
        rd_vld_r <= 1'b0;
      end else if (busy_r) begin
        rd_vld_r <= rd_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      bind_r <= req.free_scan;
      port_r <= req.port;
      cnt_r  <= '0;
    end else if (rd_en) begin
      cnt_r    <= cnt_r + CNTW'(1);
      rd_idx_r <= cnt_r[SW-1:0];
    end
  end

endmodule

// ===== src/udpd_checker.sv =====
// port-level checks for the udp port demux queue, bound to the top level
module udpd_checker import udpd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [4:0]  out_slot,
  input logic [31:0] out_src_ip,
  input logic [15:0] out_copy_len,
  input logic [15:0] out_handle
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // one item in flight: a word just taken blocks the next
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
                                   $stable(out_slot) && $stable(out_handle)))
    else $error("stalled result word changed");

  a_no_slot_codes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NO_SOCKET || out_status == ST_TABLE_FULL ||
                   out_status == ST_NOT_UDP || out_status == ST_ARP ||
                   out_status == ST_OTHER)) |-> (out_slot == 5'd0))
    else $error("slot reported for a status that uses none");

  a_data_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_src_ip == 32'd0 && out_copy_len == 16'd0 && out_handle == 16'd0))
    else $error("descriptor data on a failed word");

endmodule

bind udp_port_demux_queue_unit udpd_checker u_udpd_checker (.*);

// ===== bench/udp_port_demux_queue_unit_tb.sv =====
// self-checking bench for the udp port demux queue: directed and random words, scoreboarded
`timescale 1ns / 100ps

module udp_port_demux_queue_unit_tb;
  import udpd_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 900;
  localparam int QUIET_WORDS = 100;

  typedef struct packed {
    logic        hold;   // wait for all results before sending this word
    logic [1:0]  mode;
    logic [15:0] port;
    logic [15:0] etype;
    logic [12:0] flen;
    logic [7:0]  proto;
    logic [31:0] sip;
    logic [15:0] sport;
    logic [15:0] ulen;
    logic [15:0] handle;
    logic [15:0] maxlen;
  } req_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [31:0] sip;
    logic [15:0] sport;
    logic [15:0] copy_len;
    logic [15:0] handle;
  } rx_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [15:0] in_port;
  logic [15:0] in_ethertype;
  logic [12:0] in_frame_len;
  logic [7:0]  in_ip_protocol;
  logic [31:0] in_src_ip;
  logic [15:0] in_src_port;
  logic [15:0] in_udp_length;
  logic [15:0] in_buf_handle;
  logic [15:0] in_max_len;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [4:0]  out_slot;
  logic [31:0] out_src_ip;
  logic [15:0] out_src_port;
  logic [15:0] out_copy_len;
  logic [15:0] out_handle;

  udp_port_demux_queue_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_port        (in_port),
    .in_ethertype   (in_ethertype),
    .in_frame_len   (in_frame_len),
    .in_ip_protocol (in_ip_protocol),
    .in_src_ip      (in_src_ip),
    .in_src_port    (in_src_port),
    .in_udp_length  (in_udp_length),
    .in_buf_handle  (in_buf_handle),
    .in_max_len     (in_max_len),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_src_ip     (out_src_ip),
    .out_src_port   (out_src_port),
    .out_copy_len   (out_copy_len),
    .out_handle     (out_handle)
  );

  // shadow socket table and descriptor rings
  logic        bound_tbl [SOCKETS_DEF];
  logic [15:0] port_tbl  [SOCKETS_DEF];
  int          head_tbl  [SOCKETS_DEF];
  int          tail_tbl  [SOCKETS_DEF];
  int          fill_tbl  [SOCKETS_DEF];
  logic [31:0] desc_ip     [SOCKETS_DEF * RING_DEPTH_DEF];
  logic [15:0] desc_sport  [SOCKETS_DEF * RING_DEPTH_DEF];
  logic [15:0] desc_ulen   [SOCKETS_DEF * RING_DEPTH_DEF];
  logic [15:0] desc_handle [SOCKETS_DEF * RING_DEPTH_DEF];

  req_word_t  stim_words[$];
  rx_result_t due_results[$];
  req_word_t  cur_word;
  rx_result_t got_word;
  rx_result_t want_word;
  logic [15:0] port_pool [8];
  int send_gap;
  int stall_left;
  int fail_count;
  logic quiet_tail;

  function automatic int find_bound(input logic [15:0] p);
    int hit;
    hit = -1;
    for (int i = SOCKETS_DEF - 1; i >= 0; i--)
      if (bound_tbl[i] && port_tbl[i] == p) hit = i;
    return hit;
  endfunction

  function automatic void predict_result(input req_word_t w);
    rx_result_t r;
    int s;
    int e;
    int free_slot;
    logic [15:0] pl;
    r = '0;
    r.status = ST_OTHER;
    case (w.mode)
      MODE_BIND: begin
        free_slot = -1;
        for (int i = SOCKETS_DEF - 1; i >= 0; i--)
          if (!bound_tbl[i]) free_slot = i;
        if (free_slot < 0) begin
          r.status = ST_TABLE_FULL;
        end else begin
          port_tbl[free_slot] = w.port;
          head_tbl[free_slot] = 0;
          tail_tbl[free_slot] = 0;
          fill_tbl[free_slot] = 0;
          bound_tbl[free_slot] = 1'b1;
          r.status = ST_OK;
          r.slot = free_slot[4:0];
        end
      end
      MODE_DELIVER: begin
        if (w.etype == ETYPE_ARP && w.flen >= MIN_ARP_LEN) begin
          r.status = ST_ARP;
        end else if (w.etype == ETYPE_IPV4 && w.flen >= MIN_IP_LEN) begin
          if (w.proto != PROTO_UDP || w.flen < MIN_UDP_LEN) begin
            r.status = ST_NOT_UDP;
          end else begin
            s = find_bound(w.port);
            if (s < 0) begin
              r.status = ST_NO_SOCKET;
            end else if (fill_tbl[s] >= RING_DEPTH_DEF) begin
              r.status = ST_QUEUE_FULL;
              r.slot = s[4:0];
            end else begin
              e = s * RING_DEPTH_DEF + tail_tbl[s];
              desc_ip[e] = w.sip;
              desc_sport[e] = w.sport;
              desc_ulen[e] = w.ulen;
              desc_handle[e] = w.handle;
              tail_tbl[s] = (tail_tbl[s] + 1) % RING_DEPTH_DEF;
              fill_tbl[s]++;
              r.status = ST_OK;
              r.slot = s[4:0];
            end
          end
        end else begin
          r.status = ST_OTHER;
        end
      end
      MODE_RECEIVE: begin
        s = find_bound(w.port);
        if (s < 0) begin
          r.status = ST_NO_SOCKET;
        end else if (fill_tbl[s] == 0) begin
          r.status = ST_EMPTY;
          r.slot = s[4:0];
        end else begin
          e = s * RING_DEPTH_DEF + head_tbl[s];
          head_tbl[s] = (head_tbl[s] + 1) % RING_DEPTH_DEF;
          fill_tbl[s]--;
          pl = (desc_ulen[e] >= UDP_HDR_BYTES) ? desc_ulen[e] - UDP_HDR_BYTES : 16'd0;
          if (pl > w.maxlen) pl = w.maxlen;
          r.status = ST_OK;
          r.slot = s[4:0];
          r.sip = desc_ip[e];
          r.sport = desc_sport[e];
          r.copy_len = pl;
          r.handle = desc_handle[e];
        end
      end
      default: r.status = ST_OTHER;
    endcase
    due_results.push_back(r);
  endfunction

  function automatic req_word_t udp_frame(input logic [15:0] p);
    req_word_t w;
    w = '0;
    w.mode = MODE_DELIVER;
    w.port = p;
    w.etype = ETYPE_IPV4;
    w.flen = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(42, 4096))
                                         : 13'($urandom_range(42, 1514));
    w.proto = PROTO_UDP;
    w.sip = $urandom;
    w.sport = 16'($urandom);
    w.ulen = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1480));
    w.handle = 16'($urandom);
    return w;
  endfunction

  function automatic req_word_t recv_word(input logic [15:0] p);
    req_word_t w;
    w = '0;
    w.mode = MODE_RECEIVE;
    w.port = p;
    w.maxlen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
    return w;
  endfunction

  function automatic req_word_t bind_word(input logic [15:0] p);
    req_word_t w;
    w = '0;
    w.mode = MODE_BIND;
    w.port = p;
    return w;
  endfunction

  function automatic logic [15:0] pick_port();
    return ($urandom_range(0, 99) < 85) ? port_pool[$urandom_range(0, 7)] : 16'($urandom);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // driver: one word at a time from stim_words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_result(cur_word);
      quiet_tail <= (stim_words.size() < QUIET_WORDS);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (stim_words.size() == 0) begin
          in_valid <= 1'b0;
        end else if (stim_words[0].hold && due_results.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          cur_word = stim_words.pop_front();
          in_mode        <= cur_word.mode;
          in_port        <= cur_word.port;
          in_ethertype   <= cur_word.etype;
          in_frame_len   <= cur_word.flen;
          in_ip_protocol <= cur_word.proto;
          in_src_ip      <= cur_word.sip;
          in_src_port    <= cur_word.sport;
          in_udp_length  <= cur_word.ulen;
          in_buf_handle  <= cur_word.handle;
          in_max_len     <= cur_word.maxlen;
          in_valid       <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 6);
        end
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_word = '{out_status, out_slot, out_src_ip, out_src_port, out_copy_len, out_handle};
        if (due_results.size() == 0) begin
          $display("%0t: result word with nothing expected, actual %0h", $time, got_word);
          fail_count++;
        end else begin
          want_word = due_results.pop_front();
          check_field("status", want_word.status, got_word.status);
          check_field("slot", want_word.slot, got_word.slot);
          check_field("src_ip", want_word.sip, got_word.sip);
          check_field("src_port", want_word.sport, got_word.sport);
          check_field("copy_len", want_word.copy_len, got_word.copy_len);
          check_field("handle", want_word.handle, got_word.handle);
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 6);
      end
    end
  end

  initial begin
    req_word_t w;
    int phase;
    int roll;
    int deliver_pct;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_mode = '0;
    in_port = '0;
    in_ethertype = '0;
    in_frame_len = '0;
    in_ip_protocol = '0;
    in_src_ip = '0;
    in_src_port = '0;
    in_udp_length = '0;
    in_buf_handle = '0;
    in_max_len = '0;
    send_gap = 0;
    stall_left = 0;
    fail_count = 0;
    quiet_tail = 1'b0;
    phase = 0;
    for (int i = 0; i < SOCKETS_DEF; i++) bound_tbl[i] = 1'b0;
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) port_pool[i] = 16'($urandom);

    // directed part
    stim_words.push_back(recv_word(16'd100));           // receive before any bind
    stim_words.push_back(udp_frame(16'h0000));          // deliver with no socket
    stim_words.push_back(bind_word(16'h0000));
    stim_words.push_back(bind_word(16'hFFFF));
    stim_words.push_back(bind_word(16'h0000));          // duplicate, lowest slot wins
    stim_words.push_back(recv_word(16'h0000));          // empty ring
    w = udp_frame(16'h0000);
    w.sip = '1; w.sport = '1; w.ulen = '1; w.handle = '1;
    stim_words.push_back(w);
    w = udp_frame(16'h0000);
    w.sip = '0; w.sport = '0; w.ulen = '0; w.handle = '0;
    stim_words.push_back(w);
    w = udp_frame(16'hFFFF);
    w.ulen = 16'd7;
    stim_words.push_back(w);
    w = udp_frame(16'hFFFF);
    w.ulen = 16'd100;
    stim_words.push_back(w);
    w = recv_word(16'h0000);
    w.maxlen = 16'hFFFF;
    stim_words.push_back(w);
    w = recv_word(16'h0000);
    w.maxlen = 16'h0000;
    stim_words.push_back(w);
    w = recv_word(16'hFFFF);
    w.maxlen = 16'h0000;
    stim_words.push_back(w);
    w = recv_word(16'hFFFF);
    w.maxlen = 16'd5;                                   // clipped payload
    stim_words.push_back(w);
    w = udp_frame(16'h0000);
    w.etype = ETYPE_ARP; w.flen = MIN_ARP_LEN;
    stim_words.push_back(w);
    w.flen = MIN_ARP_LEN - 13'd1;                       // short arp falls through
    stim_words.push_back(w);
    w = udp_frame(16'h0000);
    w.flen = MIN_IP_LEN - 13'd1;
    stim_words.push_back(w);
    w.flen = MIN_IP_LEN;
    stim_words.push_back(w);
    w.flen = MIN_UDP_LEN - 13'd1;
    stim_words.push_back(w);
    w = udp_frame(16'h0000);
    w.proto = 8'd6; w.flen = 13'd1500;
    stim_words.push_back(w);
    w = udp_frame(16'h0000);
    w.flen = 13'd4096;
    stim_words.push_back(w);
    w = udp_frame(16'h0000);
    w.etype = 16'hFFFF; w.flen = 13'h1FFF; w.proto = 8'hFF;
    stim_words.push_back(w);
    w = '1;
    w.hold = 1'b0;
    w.mode = MODE_UNUSED;
    stim_words.push_back(w);
    w = udp_frame(16'h0000);
    w.etype = '0; w.flen = '0; w.proto = '0;
    stim_words.push_back(w);
    stim_words.push_back(recv_word(16'h0000));

    // random part, mix shifts between balanced, fill-heavy and drain-heavy
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) phase = $urandom_range(0, 2);
      deliver_pct = (phase == 1) ? 70 : (phase == 2) ? 25 : 45;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        w.hold = 1'b0;
        w.mode = 2'($urandom_range(0, 3));
        w.port = pick_port();
        w.etype = ($urandom_range(0, 2) == 0) ? ETYPE_ARP :
                  ($urandom_range(0, 1) == 0) ? ETYPE_IPV4 : 16'($urandom);
        w.flen = 13'($urandom_range(0, 4096));
        w.proto = ($urandom_range(0, 1) == 0) ? PROTO_UDP : 8'($urandom);
        w.sip = $urandom;
        w.sport = 16'($urandom);
        w.ulen = 16'($urandom);
        w.handle = 16'($urandom);
        w.maxlen = 16'($urandom);
      end else if (roll < 18) begin
        w = bind_word(pick_port());
      end else if (roll < 18 + deliver_pct) begin
        w = udp_frame(pick_port());
      end else begin
        w = recv_word(pick_port());
      end
      w.hold = (i == RANDOM_WORDS / 2);
      stim_words.push_back(w);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (stim_words.size() != 0 || in_valid);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SOCKETS_DEF + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("udp_port_demux_queue_unit verification clean");
    end else begin
      $display("udp_port_demux_queue_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("udp_port_demux_queue_unit verification failed");
    $finish;
  end

endmodule
